// File: rtl/core/lchs_pkg.sv
// Shared constants, codes, types and the remainder step of the linear-probe hash set.
package lchs_pkg;

  // Width of the capacity register, the live count and every slot number
  localparam int CAP_W = 7;

  // Default storage sizes
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int KEY_BITS_DEF    = 31;

  // Reset capacity never exceeds this
  localparam int CAP_RESET_MAX = 64;

  // Request commands
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_ERASE  = 2'd2;

  // Slot status codes
  localparam logic [1:0] ST_EMPTY   = 2'd0;
  localparam logic [1:0] ST_USED    = 2'd1;
  localparam logic [1:0] ST_DELETED = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_PROBE,
    S_RESP
  } state_t;

  // One restoring step of key mod capacity: shift in one key bit, subtract if needed
  function automatic logic [CAP_W-1:0] mod_step(input logic [CAP_W-1:0] rem,
                                                input logic             kbit,
                                                input logic [CAP_W-1:0] cap);
    logic [CAP_W:0] t;
    t = {rem, kbit};
    if (t >= {1'b0, cap}) begin
      t = t - {1'b0, cap};
    end
    return t[CAP_W-1:0];
  endfunction

endpackage

// File: rtl/core/linear_probe_hash_table.sv
// Top level of the linear-probe hash set: sequencer, probe walk, table store and result register.
// Flow: an accepted request runs the remainder unit, then the probe walk over P = slots walked
//   (1..capacity), then its result goes to the output register; the walk reads one slot per cycle.
//   Inserts into a full table and unused commands skip both and go straight to the result.
// A new request is taken only once the last result is in the output register, where it may wait.
// Reset, and every capacity write, runs a clearing pass over all capacity slots with s_tready low.
// Reset capacity is min(TABLE_DEPTH, 64); live count resets to zero.
module linear_probe_hash_table import lchs_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF,
  localparam int IN_W       = ((KEY_BITS + 2 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  // Request: command [1:0], key [KEY_BITS+1:2], zero pad above
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,
  // Result: success [0], occupancy [7:1]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,
  // Capacity register write
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int ENT_W = KEY_BITS + 2;
  localparam logic [CAP_W-1:0] CAP_MAX =
    (TABLE_DEPTH > 127) ? CAP_W'(127) : CAP_W'(TABLE_DEPTH);
  localparam logic [CAP_W-1:0] CAP_RST =
    (TABLE_DEPTH < CAP_RESET_MAX) ? CAP_W'(TABLE_DEPTH) : CAP_W'(CAP_RESET_MAX);

  state_t state, state_next;

  logic [CAP_W-1:0]    cap;
  logic [CAP_W-1:0]    cap_m1;
  logic [CAP_W-1:0]    cfg_cap;
  logic [CAP_W-1:0]    live_count;
  logic [CAP_W-1:0]    live_next;
  logic [CAP_W-1:0]    clr_slot;

  logic [1:0]          in_cmd;
  logic [KEY_BITS-1:0] in_key;
  logic [1:0]          cmd_r;
  logic [KEY_BITS-1:0] key_r;

  logic                cfg_fire;
  logic                in_fire;
  logic                needs_probe;

  logic                mod_start;
  logic                mod_done;
  logic [CAP_W-1:0]    mod_rem;

  logic [CAP_W-1:0]    iss_slot;
  logic [CAP_W-1:0]    iss_cnt;
  logic                iss_en;
  logic                ev_vld;
  logic [CAP_W-1:0]    ev_slot;
  logic                ev_last;
  logic                free_found;
  logic [CAP_W-1:0]    free_slot;

  logic                ram_we;
  logic [CAP_W-1:0]    ram_wslot;
  logic [ENT_W-1:0]    ram_wdata;
  logic [ENT_W-1:0]    ram_q;
  logic [1:0]          rd_st;
  logic [KEY_BITS-1:0] rd_key;

  logic                is_empty;
  logic                is_hit;
  logic                free_any;
  logic [CAP_W-1:0]    free_at;
  logic                stop;
  logic                ins_ok;
  logic                srch_ok;
  logic                era_ok;

  logic                res_success;
  logic [CAP_W-1:0]    res_occ;
  logic                out_valid;
  logic                out_success;
  logic [CAP_W-1:0]    out_occ;
  logic                out_load;

  // Unpack request fields
  assign in_cmd = s_tdata[1:0];
  assign in_key = s_tdata[KEY_BITS+1:2];

  assign cap_m1   = cap - CAP_W'(1);
  assign cfg_fire = cfg_valid && cfg_ready;
  assign in_fire  = s_tvalid && s_tready;

  // Clamp written capacity into 1..CAP_MAX
  always_comb begin
    cfg_cap = cfg_data;
    if (cfg_data == '0) begin
      cfg_cap = CAP_W'(1);
    end else if (cfg_data > CAP_MAX) begin
      cfg_cap = CAP_MAX;
    end
  end

  // Insert into a full table and unused commands answer at once
  always_comb begin
    unique case (in_cmd)
      CMD_INSERT: needs_probe = (live_count < cap);
      CMD_SEARCH: needs_probe = 1'b1;
      CMD_ERASE:  needs_probe = 1'b1;
      default:    needs_probe = 1'b0;
    endcase
  end

  // Remainder unit
  lchs_mod #(
    .KEY_BITS (KEY_BITS)
  ) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .key   (in_key),
    .cap   (cap),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // Table store: {status, key} per slot
  lchs_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(ram_wslot)),
    .wdata (ram_wdata),
    .raddr (IDX_W'(iss_slot)),
    .rdata (ram_q)
  );

  // Evaluate the slot read in the previous cycle
  assign rd_st    = ram_q[ENT_W-1:KEY_BITS];
  assign rd_key   = ram_q[KEY_BITS-1:0];
  assign is_empty = (rd_st == ST_EMPTY);
  assign is_hit   = (rd_st == ST_USED) && (rd_key == key_r);
  assign free_any = free_found || (ev_vld && rd_st != ST_USED);
  assign free_at  = free_found ? free_slot : ev_slot;
  assign stop     = (state == S_PROBE) && ev_vld && (is_empty || is_hit || ev_last);
  assign ins_ok   = stop && (cmd_r == CMD_INSERT) && !is_hit && free_any;
  assign srch_ok  = stop && (cmd_r == CMD_SEARCH) && is_hit;
  assign era_ok   = stop && (cmd_r == CMD_ERASE) && is_hit;
  assign iss_en   = (state == S_PROBE) && (iss_cnt != cap);

  // Live count after this request
  always_comb begin
    live_next = live_count;
    if (ins_ok) begin
      live_next = live_count + CAP_W'(1);
    end else if (era_ok && live_count != '0) begin
      live_next = live_count - CAP_W'(1);
    end
  end

  assign out_load = (state == S_RESP) && (!out_valid || m_tready);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (cfg_fire) begin
          state_next = S_CLEAR;
        end else if (clr_slot == cap_m1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cfg_fire) begin
          state_next = S_CLEAR;
        end else if (in_fire) begin
          state_next = needs_probe ? S_MOD : S_RESP;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (stop) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Handshakes, remainder start and table writes
  always_comb begin
    cfg_ready = (state == S_CLEAR) || (state == S_IDLE);
    s_tready  = (state == S_IDLE) && !cfg_valid;
    mod_start = (state == S_IDLE) && in_fire && needs_probe;
    ram_we    = 1'b0;
    ram_wslot = clr_slot;
    ram_wdata = {ST_EMPTY, {KEY_BITS{1'b0}}};
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_PROBE: begin
        if (ins_ok) begin
          ram_we    = 1'b1;
          ram_wslot = free_at;
          ram_wdata = {ST_USED, key_r};
        end else if (era_ok) begin
          ram_we    = 1'b1;
          ram_wslot = ev_slot;
          ram_wdata = {ST_DELETED, key_r};
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cap        <= CAP_RST;
      live_count <= '0;
      clr_slot   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_fire) begin
        cap        <= cfg_cap;
        live_count <= '0;
        clr_slot   <= '0;
      end else begin
        if (state == S_CLEAR) begin
          clr_slot <= clr_slot + CAP_W'(1);
        end
        if (stop) begin
          live_count <= live_next;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request capture, probe walk and result registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r       <= in_cmd;
      key_r       <= in_key;
      res_success <= 1'b0;
      res_occ     <= live_count;
    end
    if (mod_done) begin
      iss_slot   <= mod_rem;
      iss_cnt    <= '0;
      ev_vld     <= 1'b0;
      free_found <= 1'b0;
    end else if (state == S_PROBE) begin
      ev_vld  <= iss_en;
      ev_slot <= iss_slot;
      ev_last <= (CAP_W'(iss_cnt + CAP_W'(1)) == cap);
      if (iss_en) begin
        iss_slot <= (iss_slot == cap_m1) ? '0 : iss_slot + CAP_W'(1);
        iss_cnt  <= iss_cnt + CAP_W'(1);
      end
      if (ev_vld && !free_found && rd_st != ST_USED) begin
        free_found <= 1'b1;
        free_slot  <= ev_slot;
      end
    end
    if (stop) begin
      res_success <= ins_ok || srch_ok || era_ok;
      res_occ     <= live_next;
    end
    if (out_load) begin
      out_success <= res_success;
      out_occ     <= res_occ;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_occ, out_success};

  // Live count never runs past the capacity
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live_count <= cap)
    else $error("live count above capacity");

  // Table is written only while clearing or finishing a probe
  a_we_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_PROBE))
    else $error("table write outside clear or probe");

  // Capacity write starts a clearing pass with an empty set
  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_fire |=> (state == S_CLEAR && live_count == '0 && clr_slot == '0))
    else $error("capacity write did not clear the table");

  // Remainder completes only while the sequencer waits for it
  a_mod_done: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> state == S_MOD)
    else $error("remainder done outside hash phase");

  // Walk never issues more reads than there are slots
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_PROBE |-> iss_cnt <= cap)
    else $error("probe walk past capacity");

endmodule

// File: rtl/core/lchs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module lchs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/lchs_mod.sv
// Bit-serial remainder unit: key mod capacity, one key bit per cycle.
module lchs_mod import lchs_pkg::*; #(
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [KEY_BITS-1:0] key,
  input  logic [CAP_W-1:0]    cap,
  output logic                done,
  output logic [CAP_W-1:0]    rem
);

  localparam int CNT_W = $clog2(KEY_BITS);

  logic                running;
  logic [CNT_W-1:0]    cnt;
  logic [KEY_BITS-1:0] sh;

  // Control: run for KEY_BITS steps, pulse done with the final remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && cnt == '0) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  // Datapath: shift key out MSB first, fold each bit into the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= key;
      rem <= '0;
      cnt <= CNT_W'(KEY_BITS - 1);
    end else if (running) begin
      rem <= mod_step(rem, sh[KEY_BITS-1], cap);
      sh  <= {sh[KEY_BITS-2:0], 1'b0};
      cnt <= cnt - CNT_W'(1);
    end
  end

endmodule

// File: sim/linear_probe_hash_table_checker.sv
// Checker for the linear-probe hash set: tracks table contents and compares every result.
module linear_probe_hash_table_checker import lchs_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF,
  parameter int IN_W        = ((KEY_BITS + 2 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,     // command [1:0], key [KEY_BITS+1:2]
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [7:0]       m_tdata,     // success [0], occupancy [7:1]
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data,
  output int unsigned      error_count,
  output int unsigned      outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             ok;
    logic [CAP_W-1:0] occ;
  } outcome_t;

  // Shadow copy of the table
  logic [KEY_BITS-1:0] key_mem  [TABLE_DEPTH];
  logic [1:0]          stat_mem [TABLE_DEPTH];
  int unsigned         live;
  int unsigned         cap;

  outcome_t pending_q[$];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  function automatic void wipe_table();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      stat_mem[i] = ST_EMPTY;
    end
    live = 0;
  endfunction

  // Walk the probe path: slot holding the key (or -1) and first reusable slot (or -1)
  function automatic void walk(input logic [KEY_BITS-1:0] key, output int hit,
                               output int free_at);
    int idx;
    idx     = int'(key % cap);
    hit     = -1;
    free_at = -1;
    for (int n = 0; n < cap; n++) begin
      if (stat_mem[idx] == ST_EMPTY) begin
        if (free_at < 0) free_at = idx;
        return;
      end
      if (stat_mem[idx] == ST_USED && key_mem[idx] == key) begin
        hit = idx;
        return;
      end
      if (stat_mem[idx] != ST_USED && free_at < 0) free_at = idx;
      idx = (idx + 1 == cap) ? 0 : idx + 1;
    end
  endfunction

  // Apply one request to the shadow table and return its outcome
  function automatic outcome_t apply_request(input logic [1:0] cmd,
                                             input logic [KEY_BITS-1:0] key);
    outcome_t res;
    int       hit;
    int       free_at;
    res.ok = 1'b0;
    case (cmd)
      CMD_INSERT: begin
        if (live < cap) begin
          walk(key, hit, free_at);
          if (hit < 0 && free_at >= 0) begin
            key_mem[free_at]  = key;
            stat_mem[free_at] = ST_USED;
            live++;
            res.ok = 1'b1;
          end
        end
      end
      CMD_SEARCH: begin
        walk(key, hit, free_at);
        res.ok = (hit >= 0);
      end
      CMD_ERASE: begin
        walk(key, hit, free_at);
        if (hit >= 0) begin
          stat_mem[hit] = ST_DELETED;
          if (live > 0) live--;
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    res.occ = live[CAP_W-1:0];
    return res;
  endfunction

  // Track config writes and requests, compare results in order
  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      cap = (TABLE_DEPTH < CAP_RESET_MAX) ? TABLE_DEPTH : CAP_RESET_MAX;
      wipe_table();
      pending_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap = (cfg_data == 0) ? 1 : cfg_data;
        if (cap > TABLE_DEPTH) cap = TABLE_DEPTH;
        wipe_table();
      end
      if (s_tvalid && s_tready) begin
        pending_q.push_back(apply_request(s_tdata[1:0], s_tdata[KEY_BITS+1:2]));
      end
      if (m_tvalid && m_tready) begin
        if (pending_q.size() == 0) begin
          report_mismatch("result with no request pending", m_tdata, 0);
        end else begin
          want = pending_q.pop_front();
          if (m_tdata[0] !== want.ok) report_mismatch("success", m_tdata[0], want.ok);
          if (m_tdata[7:1] !== want.occ) report_mismatch("occupancy", m_tdata[7:1], want.occ);
        end
      end
    end
    outstanding <= pending_q.size();
  end

endmodule

// File: sim/linear_probe_hash_table_tb.sv
// Testbench top for the linear-probe hash set: clock, reset, request stimulus and verdict.
module linear_probe_hash_table_tb import lchs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TABLE_DEPTH = TABLE_DEPTH_DEF;
  localparam int          KEY_BITS    = KEY_BITS_DEF;
  localparam int          IN_W        = ((KEY_BITS + 2 + 7) / 8) * 8;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam int          HOLD_CYCLES = 600;
  localparam int unsigned RUN_LIMIT   = 1_500_000;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata   = '0;     // command [1:0], key [KEY_BITS+1:2]
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [7:0]          m_tdata;            // success [0], occupancy [7:1]
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CAP_W-1:0]    cfg_data  = '0;

  int unsigned         error_count;
  int unsigned         outstanding;
  int unsigned         cycle_count = 0;

  // Receiver pacing, shared with the stimulus process
  int unsigned         recv_idle = 0;
  int unsigned         hold_ask  = 0;
  int unsigned         hold_seen = 0;
  int unsigned         hold_left = 0;

  // Stimulus-side state
  int unsigned         send_idle = 0;
  int unsigned         eff_cap   = 64;
  logic [KEY_BITS-1:0] big_keys [4];

  always #5 clk = ~clk;

  linear_probe_hash_table i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  linear_probe_hash_table_checker #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .IN_W        (IN_W)
  ) i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  // Drop the run if it hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off when the stimulus asks for one
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Offer one request and hold it until accepted
  task automatic offer_request(input logic [1:0] cmd, input logic [KEY_BITS-1:0] key);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_W - KEY_BITS - 2){1'b0}}, key, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop sending and wait for every pending result
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    eff_cap = (value == 0) ? 1 : ((value > TABLE_DEPTH) ? TABLE_DEPTH : value);
  endtask

  // Mostly small colliding keys, some reused wide keys, a few fully random ones
  task automatic random_request();
    logic [1:0]          cmd;
    logic [KEY_BITS-1:0] key;
    int unsigned         pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      cmd = CMD_INSERT;
    else if (pick < 70) cmd = CMD_SEARCH;
    else if (pick < 95) cmd = CMD_ERASE;
    else                cmd = CMD_UNUSED;
    pick = $urandom_range(0, 99);
    if (pick < 70)      key = KEY_BITS'($urandom_range(0, 3 * eff_cap));
    else if (pick < 90) key = big_keys[$urandom_range(0, 3)];
    else                key = KEY_BITS'($urandom() & 32'h7FFF_FFFF);
    offer_request(cmd, key);
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] capacity, input int items,
                           input int unsigned s_idle, input int unsigned r_idle,
                           input bit with_hold);
    drain();
    write_capacity(capacity);
    recv_idle <= r_idle;
    send_idle = s_idle;
    for (int i = 0; i < 4; i++) begin
      big_keys[i] = KEY_BITS'($urandom() & 32'h7FFF_FFFF);
    end
    for (int i = 0; i < items; i++) begin
      if (with_hold && i == items / 3) hold_ask <= hold_ask + 1;
      if (i == items / 2) drain();
      random_request();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: collisions, tombstones, duplicates, full table, wrap without empty slot
    drain();
    write_capacity(7'd4);
    offer_request(CMD_INSERT, 31'd0);
    offer_request(CMD_INSERT, 31'd4);
    offer_request(CMD_INSERT, 31'd8);
    offer_request(CMD_INSERT, 31'd4);
    offer_request(CMD_SEARCH, 31'd8);
    offer_request(CMD_ERASE,  31'd4);
    offer_request(CMD_SEARCH, 31'd8);
    offer_request(CMD_INSERT, 31'd8);
    offer_request(CMD_INSERT, 31'h7FFF_FFFF);
    offer_request(CMD_INSERT, 31'd12);
    offer_request(CMD_INSERT, 31'd5);
    offer_request(CMD_SEARCH, 31'd1);
    offer_request(CMD_ERASE,  31'd1);
    offer_request(CMD_ERASE,  31'd0);
    offer_request(CMD_SEARCH, 31'd16);
    offer_request(CMD_INSERT, 31'd16);
    offer_request(CMD_UNUSED, 31'h7FFF_FFFF);
    offer_request(CMD_UNUSED, 31'd0);
    offer_request(CMD_SEARCH, 31'h7FFF_FFFF);
    offer_request(CMD_ERASE,  31'h7FFF_FFFF);

    // Zero capacity acts as a single slot
    drain();
    write_capacity(7'd0);
    offer_request(CMD_INSERT, 31'h5555_5555);
    offer_request(CMD_INSERT, 31'h2AAA_AAAA);
    offer_request(CMD_SEARCH, 31'h5555_5555);
    offer_request(CMD_ERASE,  31'h5555_5555);
    offer_request(CMD_ERASE,  31'h5555_5555);
    offer_request(CMD_INSERT, 31'h2AAA_AAAA);
    offer_request(CMD_SEARCH, 31'h5555_5555);

    // Random: sender rarely idle, receiver mostly stalled
    run_phase(7'd127, 250, 17, 83, 1'b1);
    run_phase(7'd3,   100, 17, 83, 1'b0);
    // Sender mostly idle, receiver rarely stalled
    run_phase(7'd1,    80, 83, 17, 1'b0);
    run_phase(7'd16,  200, 83, 17, 1'b0);
    // Full rate on both sides, but for one long receiver hold-off in the first phase
    run_phase(7'd64,  300, 0, 0, 1'b1);
    run_phase(7'd7,   150, 0, 0, 1'b0);
    run_phase(7'd2,    60, 0, 0, 1'b0);
    run_phase(7'd100,  60, 0, 0, 1'b0);

    // Let any stray result show up before the verdict
    drain();
    repeat (KEY_BITS + TABLE_DEPTH + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
